>>> rtl/core/cgapg_pkg.sv
// ----------------------------------------------------------------------------
// cgapg_pkg
// Shared types, constants and color helpers of the CGA pixel generator.
// ----------------------------------------------------------------------------
package cgapg_pkg;

    // Default size of the character font store in bytes.
    localparam int FONT_BYTES_DEFAULT = 8192;

    // Width of the font address field on the input stream.
    localparam int FONT_ADDR_W = 13;

    // Glyph base addresses for scanlines 8 to 15 and 0 to 7 of a character cell.
    localparam logic [13:0] GLYPH_HIGH_BASE = 14'h1800;
    localparam logic [13:0] GLYPH_LOW_BASE  = 14'h1000;

    // Channel intensities.
    localparam logic [7:0] LEVEL_OFF    = 8'h00;
    localparam logic [7:0] LEVEL_NORMAL = 8'hAA;
    localparam logic [7:0] LEVEL_BRIGHT = 8'hFF;

    // Depth of the queue between the front and the back end.
    localparam int QUEUE_DEPTH = 4;

    // Command codes on the input stream.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_RENDER = 1'b1;

    // Display mode register bits.
    localparam int MODE_GRAPHICS_BIT = 1;
    localparam int MODE_HIRES_BIT    = 4;

    // Kind of pixel run that one render item produces.
    typedef enum logic [1:0] {
        KIND_TEXT = 2'd0,
        KIND_GFX2 = 2'd1,
        KIND_GFX1 = 2'd2
    } kind_t;

    // One render job handed from the front to the back end.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] pixels;     // glyph row in text mode, packed pixels in graphics
        logic [7:0] attribute;
    } job_t;

    // Queue status seen by the front and the back end.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // One pixel color.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // Text color from three color bits (red, green, blue = bits 2, 1, 0).
    function automatic rgb_t text_color(input logic [2:0] bits3, input logic bright);
        logic [7:0] level;
        rgb_t       c;
        level   = bright ? LEVEL_BRIGHT : LEVEL_NORMAL;
        c.red   = bits3[2] ? level : LEVEL_OFF;
        c.green = bits3[1] ? level : LEVEL_OFF;
        c.blue  = bits3[0] ? level : LEVEL_OFF;
        return c;
    endfunction

    // Fixed 2bpp graphics palette.
    function automatic rgb_t gfx_palette(input logic [1:0] index);
        rgb_t c;
        case (index)
            2'd0:    c = '{LEVEL_OFF,    LEVEL_OFF,    LEVEL_NORMAL};
            2'd1:    c = '{LEVEL_OFF,    LEVEL_NORMAL, LEVEL_NORMAL};
            2'd2:    c = '{LEVEL_NORMAL, LEVEL_OFF,    LEVEL_NORMAL};
            default: c = '{LEVEL_BRIGHT, LEVEL_BRIGHT, LEVEL_BRIGHT};
        endcase
        return c;
    endfunction

endpackage

>>> rtl/core/cgapg_front.sv
// ----------------------------------------------------------------------------
// cgapg_front
// Accepts items, writes the font store on loads and classifies render items,
// fetching the glyph row in text mode before handing a job to the queue.
// ----------------------------------------------------------------------------
module cgapg_front
    import cgapg_pkg::*;
#(
    parameter int FONT_BYTES = FONT_BYTES_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [7:0]             display_mode,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   command,
    input  logic [FONT_ADDR_W-1:0] font_address,
    input  logic [7:0]             font_data,
    input  logic [7:0]             memory_byte,
    input  logic [7:0]             attribute,
    input  logic [3:0]             scanline,
    input  q_status_t              q_status,
    output logic                   push_valid,
    output job_t                   push_job
);

    localparam int          IDX_W      = $clog2(FONT_BYTES);
    localparam logic [13:0] FONT_LIMIT = 14'(FONT_BYTES);

    logic [7:0] font_mem [0:FONT_BYTES-1];

    logic       accept;
    logic       push_ok;
    logic [13:0] glyph_addr;
    logic [13:0] glyph_wrap;
    logic       load_in_range;
    kind_t      kind_in;

    logic       b_valid_reg;
    logic       b_valid_next;
    kind_t      b_kind_reg;
    logic [7:0] b_mem_reg;
    logic [7:0] b_attr_reg;
    logic [7:0] rd_data_reg;

    // Handshake: a new item enters when the holding stage is free or drains.
    assign push_ok  = b_valid_reg && !q_status.full;
    assign in_ready = !b_valid_reg || !q_status.full;
    assign accept   = in_valid && in_ready;

    // Glyph address, wrapped once into the store size.
    always_comb
    begin
        if (scanline[3])
        begin
            glyph_addr = GLYPH_HIGH_BASE + {3'b000, memory_byte, 3'b000}
                       + {11'd0, scanline[2:0]};
        end
        else
        begin
            glyph_addr = GLYPH_LOW_BASE + {3'b000, memory_byte, 3'b000}
                       + {10'd0, scanline};
        end
        glyph_wrap = (glyph_addr >= FONT_LIMIT) ? glyph_addr - FONT_LIMIT : glyph_addr;
    end

    assign load_in_range = {1'b0, font_address} < FONT_LIMIT;

    // Classify the render item from the display mode.
    always_comb
    begin
        if (display_mode[MODE_GRAPHICS_BIT])
        begin
            kind_in = display_mode[MODE_HIRES_BIT] ? KIND_GFX1 : KIND_GFX2;
        end
        else
        begin
            kind_in = KIND_TEXT;
        end
    end

    // Font store: one write port for loads, one registered read for renders.
    always_ff @(posedge clk)
    begin
        if (accept && command == CMD_LOAD && load_in_range)
        begin
            font_mem[font_address[IDX_W-1:0]] <= font_data;
        end
        if (accept && command == CMD_RENDER)
        begin
            rd_data_reg <= font_mem[glyph_wrap[IDX_W-1:0]];
        end
    end

    // Holding stage occupancy.
    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (push_ok)
        begin
            b_valid_next = 1'b0;
        end
        if (accept && command == CMD_RENDER)
        begin
            b_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
        end
    end

    // Holding stage payload.
    always_ff @(posedge clk)
    begin
        if (accept && command == CMD_RENDER)
        begin
            b_kind_reg <= kind_in;
            b_mem_reg  <= memory_byte;
            b_attr_reg <= attribute;
        end
    end

    // Job toward the queue.
    assign push_valid         = b_valid_reg;
    assign push_job.kind      = b_kind_reg;
    assign push_job.pixels    = (b_kind_reg == KIND_TEXT) ? rd_data_reg : b_mem_reg;
    assign push_job.attribute = b_attr_reg;

endmodule

>>> rtl/core/cgapg_queue.sv
// ----------------------------------------------------------------------------
// cgapg_queue
// Short job queue that decouples the front end from the pixel back end.
// ----------------------------------------------------------------------------
module cgapg_queue
    import cgapg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  job_t      push_job,
    input  logic      pop,
    output job_t      head_job,
    output q_status_t q_status
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             slots [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign q_status.full  = count_reg == CNT_W'(QUEUE_DEPTH);
    assign q_status.empty = count_reg == '0;
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head_job       = slots[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

endmodule

>>> rtl/core/cgapg_back.sv
// ----------------------------------------------------------------------------
// cgapg_back
// Expands the job at the queue head into pixels, one per cycle while the
// queue holds a job and the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module cgapg_back
    import cgapg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  job_t        head_job,
    input  q_status_t   q_status,
    output logic        pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam logic [2:0] LAST_GFX2 = 3'd3;
    localparam logic [2:0] LAST_FULL = 3'd7;

    logic [2:0]  pix_reg;
    logic [2:0]  pix_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic [23:0] m_data_reg;
    logic        m_last_reg;
    logic        step;
    logic        is_last;
    logic [2:0]  last_index;
    logic [1:0]  pair;
    rgb_t        color;

    assign step = !q_status.empty && (!m_valid_reg || m_axis_tready);
    assign last_index = (head_job.kind == KIND_GFX2) ? LAST_GFX2 : LAST_FULL;
    assign is_last = pix_reg == last_index;
    assign pop = step && is_last;
    assign pair = head_job.pixels[{pix_reg[1:0], 1'b0} +: 2];

    // Color of the current pixel.
    always_comb
    begin
        case (head_job.kind)
            KIND_TEXT:
            begin
                // Glyph bits go out most significant first.
                if (head_job.pixels[~pix_reg])
                begin
                    color = text_color(head_job.attribute[2:0], head_job.attribute[3]);
                end
                else
                begin
                    color = text_color(head_job.attribute[6:4], head_job.attribute[7]);
                end
            end
            KIND_GFX2:
            begin
                color = gfx_palette(pair);
            end
            KIND_GFX1:
            begin
                if (head_job.pixels[pix_reg])
                begin
                    color = '{LEVEL_BRIGHT, LEVEL_BRIGHT, LEVEL_BRIGHT};
                end
                else
                begin
                    color = '{LEVEL_OFF, LEVEL_OFF, LEVEL_OFF};
                end
            end
            default:
            begin
                color = '{LEVEL_OFF, LEVEL_OFF, LEVEL_OFF};
            end
        endcase
    end

    // Pixel counter and output valid.
    always_comb
    begin
        pix_next = pix_reg;
        if (pop)
        begin
            pix_next = '0;
        end
        else if (step)
        begin
            pix_next = pix_reg + 1'b1;
        end

        if (step)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        else
        begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            pix_reg     <= pix_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            m_data_reg <= {color.blue, color.green, color.red};
            m_last_reg <= is_last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

>>> rtl/core/cga_pixel_generator_unit.sv
// ----------------------------------------------------------------------------
// cga_pixel_generator_unit
// CGA-style text and graphics pixel generator with a loadable font store.
// ----------------------------------------------------------------------------
// The slave stream carries one item per handshake: tuser holds the command
// (load a font byte or render one video memory byte), tdata the fields.
// A load writes the font store and produces no pixels. A render produces a
// run of 8 pixels in text and 1bpp graphics modes, or 4 pixels in 2bpp
// graphics mode, on the master stream; tlast marks the last pixel of a run.
// The display mode register is written through the cfg channel; the user
// must write it only while the block is idle, as the block itself does not
// enforce this; cfg_ready is always high. A render passes the holding
// stage, where the font store is read, and the queue to the output register.
// Throughput is one pixel per cycle while the queue holds a job and the
// receiver does not stall, set by the pixel back end; loads enter neither
// the holding stage nor the queue. The front end keeps accepting items
// while the back end works, until the queue of 4 jobs is full and a job
// waits in the holding stage. When the receiver stalls, the output register
// holds its pixel and the queue then fills. Reset empties the queue and the
// stages and clears the display mode; the font store is not cleared.
// ----------------------------------------------------------------------------
module cga_pixel_generator_unit
    import cgapg_pkg::*;
#(
    parameter int FONT_BYTES = FONT_BYTES_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,      // display_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // font_address, font_data, memory_byte,
                                       // attribute, scanline, zero fill
    input  logic        s_axis_tuser,  // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // red, green, blue
    output logic        m_axis_tlast
);

    logic [7:0] mode_reg;
    logic       push_valid;
    job_t       push_job;
    job_t       head_job;
    q_status_t  q_status;
    logic       pop;

    // Display mode register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= cfg_data;
        end
    end

    // Front end: loads and classification.
    cgapg_front #(
        .FONT_BYTES (FONT_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .display_mode (mode_reg),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .command      (s_axis_tuser),
        .font_address (s_axis_tdata[12:0]),
        .font_data    (s_axis_tdata[20:13]),
        .memory_byte  (s_axis_tdata[28:21]),
        .attribute    (s_axis_tdata[36:29]),
        .scanline     (s_axis_tdata[40:37]),
        .q_status     (q_status),
        .push_valid   (push_valid),
        .push_job     (push_job)
    );

    // Job queue.
    cgapg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push_valid),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .q_status (q_status)
    );

    // Pixel back end.
    cgapg_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_job      (head_job),
        .q_status      (q_status),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    // The back end never finishes a job that the queue does not hold.
    a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pixel run finished with an empty queue");

    // A job held in the front stage stays until the queue takes it.
    a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
        push_valid && q_status.full |=> push_valid && $stable(push_job))
        else $error("front job lost while the queue was full");

    // The front end stalls only while its holding stage waits on a full queue.
    a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> push_valid && q_status.full)
        else $error("input stalled without a full queue");
`endif

endmodule
